@@ hdl/dtc_pkg.sv @@
`timescale 1ns / 1ps

package dtc_pkg;

  localparam int QW = 16;
  localparam int NW = 17;
  localparam int CHANNELS = 3;
  localparam int KNOTS = 5;

  localparam logic [NW-1:0] ONE_Q16 = 17'h10000;

  typedef enum logic [1:0] {
    REG_DEPTH_LO = 2'd0,
    REG_DEPTH_HI = 2'd1,
    REG_COLORIZE = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic zero;
    logic one;
  } nclass_t;

  // Turbo knots in Q0.16, rows are red, green and blue.
  localparam logic [15:0] KNOT [CHANNELS][KNOTS] = '{
    '{16'd12449, 16'd23094, 16'd37306, 16'd61753, 16'd64647},
    '{16'd4703,  16'd22472, 16'd50504, 16'd58596, 16'd30747},
    '{16'd15215, 16'd61218, 16'd30746, 16'd6668,  16'd5237}
  };

endpackage

@@ hdl/dtc_norm.sv @@
`timescale 1ns / 1ps

module dtc_norm #(
  parameter int W  = 32,
  parameter int RW = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [W-1:0]          d,
  input  logic [W-1:0]          lo,
  input  logic [W-1:0]          hi,
  output logic                  out_valid,
  output logic [RW-1:0]         rem,
  output logic [RW-1:0]         rng,
  output dtc_pkg::nclass_t      cls
);

  logic          v1;
  logic [W-1:0]  diff1;
  logic          below1;
  logic [RW-1:0] rng1;
  logic [W-1:0]  span;
  logic [RW-1:0] diff_ext;

  assign span     = hi - lo;
  assign diff_ext = RW'(diff1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    diff1    <= d - lo;
    below1   <= (d <= lo);
    rng1     <= (hi > lo) ? RW'(span) : RW'(dtc_pkg::ONE_Q16);
    rem      <= diff_ext;
    rng      <= rng1;
    cls.zero <= below1;
    cls.one  <= !below1 && (diff_ext >= rng1);
  end

endmodule

@@ hdl/dtc_div.sv @@
`timescale 1ns / 1ps

module dtc_div #(
  parameter int RW = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [RW-1:0]             rem_in,
  input  logic [RW-1:0]             rng_in,
  input  dtc_pkg::nclass_t          cls_in,
  output logic                      out_valid,
  output logic [dtc_pkg::QW-1:0]    quo,
  output dtc_pkg::nclass_t          cls_out
);

  localparam int QW = dtc_pkg::QW;

  logic                 vld     [QW];
  logic [RW-1:0]        rem     [QW];
  logic [RW-1:0]        rng     [QW];
  logic [QW-1:0]        qt      [QW];
  dtc_pkg::nclass_t     cls     [QW];
  logic [RW-1:0]        rem_next[QW];
  logic [QW-1:0]        qt_next [QW];

  // One quotient bit per stage: shift the remainder, compare and subtract.
  always_comb begin
    logic [RW:0] r2;
    logic        ge;
    r2 = {rem_in, 1'b0};
    ge = (r2 >= {1'b0, rng_in});
    rem_next[0] = ge ? RW'(r2 - {1'b0, rng_in}) : r2[RW-1:0];
    qt_next[0]  = QW'(ge);
    for (int i = 1; i < QW; i++) begin
      r2 = {rem[i-1], 1'b0};
      ge = (r2 >= {1'b0, rng[i-1]});
      rem_next[i] = ge ? RW'(r2 - {1'b0, rng[i-1]}) : r2[RW-1:0];
      qt_next[i]  = {qt[i-1][QW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < QW; i++) vld[i] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
      for (int i = 1; i < QW; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    rng[0] <= rng_in;
    cls[0] <= cls_in;
    for (int i = 1; i < QW; i++) begin
      rng[i] <= rng[i-1];
      cls[i] <= cls[i-1];
    end
    for (int i = 0; i < QW; i++) begin
      rem[i] <= rem_next[i];
      qt[i]  <= qt_next[i];
    end
  end

  assign out_valid = vld[QW-1];
  assign quo       = qt[QW-1];
  assign cls_out   = cls[QW-1];

endmodule

@@ hdl/dtc_cmap.sv @@
`timescale 1ns / 1ps

module dtc_cmap (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic [dtc_pkg::QW-1:0]  quo,
  input  dtc_pkg::nclass_t        cls,
  input  logic                    colorize,
  output logic                    done,
  output logic [7:0]              red,
  output logic [7:0]              green,
  output logic [7:0]              blue
);

  localparam int NW = dtc_pkg::NW;
  localparam int CH = dtc_pkg::CHANNELS;
  localparam int PW = 2 * NW + 1;

  logic [NW-1:0]        n;
  logic [1:0]           seg;
  logic [NW-1:0]        t;
  logic [NW+7:0]        grey_full;
  logic signed [PW-1:0] prod_next [CH];

  logic                 v1, v2;
  logic [15:0]          a1   [CH];
  logic signed [PW-1:0] p1   [CH];
  logic [7:0]           g1, g2;
  logic [15:0]          c2   [CH];
  logic signed [PW-1:0] sum  [CH];
  logic [23:0]          sc   [CH];

  always_comb begin
    logic signed [NW-1:0] delta;
    if (cls.zero) begin
      n = '0;
    end else if (cls.one) begin
      n = dtc_pkg::ONE_Q16;
    end else begin
      n = {1'b0, quo};
    end
    seg       = cls.one ? 2'd3 : n[15:14];
    t         = cls.one ? dtc_pkg::ONE_Q16 : {1'b0, n[13:0], 2'b00};
    grey_full = {n, 8'b0} - {8'b0, n};
    for (int c = 0; c < CH; c++) begin
      delta = $signed({1'b0, dtc_pkg::KNOT[c][seg + 3'd1]})
            - $signed({1'b0, dtc_pkg::KNOT[c][seg]});
      prod_next[c] = PW'($signed({1'b0, t})) * PW'(delta);
    end
  end

  // The arithmetic shift floors the signed product.
  always_comb begin
    for (int c = 0; c < CH; c++) begin
      sum[c] = PW'($signed({1'b0, a1[c]})) + (p1[c] >>> 16);
      sc[c]  = {c2[c], 8'b0} - {8'b0, c2[c]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= in_valid;
      v2   <= v1;
      done <= v2;
    end
  end

  always_ff @(posedge clk) begin
    g1 <= grey_full[23:16];
    g2 <= g1;
    for (int c = 0; c < CH; c++) begin
      a1[c] <= dtc_pkg::KNOT[c][seg];
      p1[c] <= prod_next[c];
      c2[c] <= sum[c][15:0];
    end
    red   <= colorize ? sc[0][23:16] : g2;
    green <= colorize ? sc[1][23:16] : g2;
    blue  <= colorize ? sc[2][23:16] : g2;
  end

endmodule

@@ hdl/depth_to_turbo_colormap_top.sv @@
`timescale 1ns / 1ps

// Maps one unsigned Q16.16 depth pixel to an 8-bit RGB color, either through a
// four-segment turbo colormap or as grey, after normalizing it against the
// lower and upper depth registers. The block takes one item on every clock
// (busy is always low) and returns each result on red, green and blue with a
// one-cycle done strobe. The receiver cannot stall, so results must be
// captured when done is high. The pipeline is mostly the 16-stage normalizing
// divider, one quotient bit per stage; an input register, two normalizing
// stages and three colormap stages make up the rest.
// Write the registers only while no item is in flight.
module depth_to_turbo_colormap_top #(
  parameter int DEPTH_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] depth,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        done,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue
);

  localparam int W   = (DEPTH_WIDTH < 32) ? DEPTH_WIDTH : 32;
  localparam int RW  = (W > dtc_pkg::NW) ? W : dtc_pkg::NW;
  localparam int LAT = 3 + dtc_pkg::QW + 3;

  logic [W-1:0]      depth_lo;
  logic [W-1:0]      depth_hi;
  logic              colorize;
  logic              v0;
  logic [W-1:0]      d0;
  logic              norm_valid;
  logic [RW-1:0]     norm_rem;
  logic [RW-1:0]     norm_rng;
  dtc_pkg::nclass_t  norm_cls;
  logic              div_valid;
  logic [dtc_pkg::QW-1:0] div_quo;
  dtc_pkg::nclass_t  div_cls;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_lo <= '0;
      depth_hi <= W'(dtc_pkg::ONE_Q16);
      colorize <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        dtc_pkg::REG_DEPTH_LO: depth_lo <= cfg_data[W-1:0];
        dtc_pkg::REG_DEPTH_HI: depth_hi <= cfg_data[W-1:0];
        dtc_pkg::REG_COLORIZE: colorize <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    d0 <= depth[W-1:0];
  end

  dtc_norm #(.W(W), .RW(RW)) u_norm (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v0),
    .d         (d0),
    .lo        (depth_lo),
    .hi        (depth_hi),
    .out_valid (norm_valid),
    .rem       (norm_rem),
    .rng       (norm_rng),
    .cls       (norm_cls)
  );

  dtc_div #(.RW(RW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (norm_valid),
    .rem_in    (norm_rem),
    .rng_in    (norm_rng),
    .cls_in    (norm_cls),
    .out_valid (div_valid),
    .quo       (div_quo),
    .cls_out   (div_cls)
  );

  dtc_cmap u_cmap (
    .clk      (clk),
    .rst      (rst),
    .in_valid (div_valid),
    .quo      (div_quo),
    .cls      (div_cls),
    .colorize (colorize),
    .done     (done),
    .red      (red),
    .green    (green),
    .blue     (blue)
  );

`ifndef SYNTHESIS
  a_latency_fwd: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("An accepted item produced no result after the pipeline latency.");

  a_latency_bwd: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("A result appeared without a matching accepted item.");

  a_grey_equal: assert property (@(posedge clk) disable iff (rst)
    (done && !$past(colorize)) |-> (red == green && green == blue))
    else $error("Grey output channels differ.");
`endif

endmodule

@@ test/depth_to_turbo_colormap_top_tb.sv @@
`timescale 1ns / 1ps

module depth_to_turbo_colormap_top_tb;

  localparam int LATENCY = 22;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PIXELS = 1150;

  localparam logic [1:0] REG_UNUSED = 2'd3;

  localparam logic [31:0] DEPTH_MAX = 32'hFFFF_FFFF;
  localparam longint unsigned ONE_Q16 = 64'd65536;

  // Turbo knots in Q0.16, knot 0 in the lowest slot.
  localparam logic [4:0][15:0] TURBO_RED =
    {16'd64647, 16'd61753, 16'd37306, 16'd23094, 16'd12449};
  localparam logic [4:0][15:0] TURBO_GREEN =
    {16'd30747, 16'd58596, 16'd50504, 16'd22472, 16'd4703};
  localparam logic [4:0][15:0] TURBO_BLUE =
    {16'd5237, 16'd6668, 16'd30746, 16'd61218, 16'd15215};

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } color_t;

  typedef enum logic {
    ROW_WRITE,
    ROW_PIXEL
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  idx;
    logic [31:0] value;
    logic        known;
    color_t      color;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] depth = '0;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        done;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;

  logic [31:0] min_q = 32'd0;
  logic [31:0] max_q = 32'h0001_0000;
  logic        colorize_q = 1'b1;

  color_t    expected_colors[$];
  plan_row_t plan[$];
  int        mismatches = 0;
  int        pixels_sent = 0;
  int        stall_cycles = 0;

  depth_to_turbo_colormap_top #(
    .DEPTH_WIDTH(32)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .depth(depth),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .done(done),
    .red(red),
    .green(green),
    .blue(blue)
  );

  always #2 clk = ~clk;

  function automatic logic [16:0] norm_depth(input logic [31:0] d);
    longint unsigned lo, hi, span, diff;
    lo = min_q;
    hi = max_q;
    span = (hi > lo) ? hi - lo : ONE_Q16;
    if (d <= lo) return 17'd0;
    diff = d - lo;
    if (diff >= span) return 17'h10000;
    return 17'((diff << 16) / span);
  endfunction

  function automatic logic [7:0] lerp_knot(input logic [4:0][15:0] k, input int s,
                                           input longint unsigned t);
    longint unsigned a, b;
    longint c, v;
    a = k[s];
    b = k[s + 1];
    if (b >= a) begin
      c = a + ((t * (b - a)) >> 16);
    end else begin
      c = a - ((t * (a - b) + 65535) >> 16);
    end
    if (c < 0) c = 0;
    v = (c * 255) >> 16;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic color_t color_of_depth(input logic [31:0] d);
    logic [16:0] n;
    int s;
    longint unsigned t, grey;
    color_t c;
    n = norm_depth(d);
    if (colorize_q) begin
      if (n >= 17'h10000) begin
        s = 3;
        t = ONE_Q16;
      end else begin
        s = int'(n >> 14);
        t = longint'(n & 17'h3FFF) << 2;
      end
      c.r = lerp_knot(TURBO_RED, s, t);
      c.g = lerp_knot(TURBO_GREEN, s, t);
      c.b = lerp_knot(TURBO_BLUE, s, t);
    end else begin
      grey = (longint'(n) * 255) >> 16;
      if (grey > 255) grey = 255;
      c.r = grey[7:0];
      c.g = grey[7:0];
      c.b = grey[7:0];
    end
    return c;
  endfunction

  function automatic logic [31:0] pick_depth();
    longint unsigned lo, hi, span, pick;
    int sel;
    lo = min_q;
    hi = max_q;
    sel = $urandom_range(0, 9);
    if (sel == 0) return $urandom;
    if (sel == 1) return min_q;
    if (sel == 2) return max_q;
    if (sel == 3) return 32'(lo + $urandom_range(0, 4) - 2);
    if (hi > lo) begin
      span = hi - lo;
      pick = {$urandom, $urandom} % (span + span / 8 + 1);
      return 32'(lo + pick);
    end
    return 32'(lo + $urandom_range(0, 32'h2_0000) - 32'h8000);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  task automatic add_pixel(input logic [31:0] d);
    plan.push_back('{ROW_PIXEL, 2'd0, d, 1'b0, color_t'(0)});
  endtask

  task automatic add_known(input logic [31:0] d, input logic [7:0] r, input logic [7:0] g,
                           input logic [7:0] b);
    plan.push_back('{ROW_PIXEL, 2'd0, d, 1'b1, color_t'({r, g, b})});
  endtask

  task automatic add_write(input logic [1:0] idx, input logic [31:0] v);
    plan.push_back('{ROW_WRITE, idx, v, 1'b0, color_t'(0)});
  endtask

  task automatic send_pixel(input logic [31:0] d, input int gap, input color_t want);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    depth <= d;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_colors.push_back(want);
    pixels_sent++;
  endtask

  task automatic stop_and_drain();
    @(negedge clk);
    start <= 1'b0;
    while (expected_colors.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] v);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    case (idx)
      dtc_pkg::REG_DEPTH_LO: min_q = v;
      dtc_pkg::REG_DEPTH_HI: max_q = v;
      dtc_pkg::REG_COLORIZE: colorize_q = v[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic new_window();
    longint unsigned lo, span, hi;
    int mode, w;
    mode = $urandom_range(0, 9);
    if ($urandom_range(0, 4) == 0) write_reg(REG_UNUSED, $urandom);
    case (mode)
      0: begin
        lo = 0;
        hi = DEPTH_MAX;
      end
      1: begin
        lo = $urandom;
        hi = lo;
      end
      2: begin
        lo = $urandom;
        hi = $urandom;
      end
      3: begin
        lo = $urandom_range(0, 1) ? DEPTH_MAX : 0;
        hi = lo;
      end
      default: begin
        lo = $urandom >> $urandom_range(0, 31);
        w = $urandom_range(0, 31);
        span = ({$urandom, $urandom} & ((64'd1 << w) - 1)) + 1;
        hi = lo + span;
        if (hi > DEPTH_MAX) hi = DEPTH_MAX;
      end
    endcase
    write_reg(dtc_pkg::REG_DEPTH_LO, 32'(lo));
    write_reg(dtc_pkg::REG_DEPTH_HI, 32'(hi));
    write_reg(dtc_pkg::REG_COLORIZE,
              {31'($urandom_range(0, 32'h7FFF_FFFF)), 1'($urandom_range(0, 3) != 0)});
  endtask

  always @(posedge clk) begin
    color_t want;
    if (!rst && done) begin
      if (expected_colors.size() == 0) begin
        $display("%0t: result with none expected, got %0d %0d %0d", $time, red, green,
                 blue);
        mismatches++;
      end else begin
        want = expected_colors.pop_front();
        if (red !== want.r) begin
          $display("%0t: red expected %0d, got %0d", $time, want.r, red);
          mismatches++;
        end
        if (green !== want.g) begin
          $display("%0t: green expected %0d, got %0d", $time, want.g, green);
          mismatches++;
        end
        if (blue !== want.b) begin
          $display("%0t: blue expected %0d, got %0d", $time, want.b, blue);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    color_t want;
    int phase_len, burst;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: min 0, max 1.0, turbo on.
    add_known(32'd0, 8'd48, 8'd18, 8'd59);
    add_known(DEPTH_MAX, 8'd251, 8'd119, 8'd20);
    add_known(32'h0001_0000, 8'd251, 8'd119, 8'd20);
    add_pixel(32'h0000_8000);
    add_pixel(32'h0000_4000);
    add_pixel(32'h0000_C000);
    add_pixel(32'h0000_FFFF);
    add_pixel(32'h0000_0001);
    // Grey mode, with the upper bits of the write set.
    add_write(dtc_pkg::REG_COLORIZE, 32'hFFFF_FFFE);
    add_known(32'd0, 8'd0, 8'd0, 8'd0);
    add_known(DEPTH_MAX, 8'd255, 8'd255, 8'd255);
    add_pixel(32'h0000_8000);
    // Reversed range falls back to a span of 1.0.
    add_write(dtc_pkg::REG_DEPTH_LO, 32'h0005_0000);
    add_write(dtc_pkg::REG_DEPTH_HI, 32'h0003_0000);
    add_known(32'h0004_0000, 8'd0, 8'd0, 8'd0);
    add_pixel(32'h0005_8000);
    // Empty range.
    add_write(dtc_pkg::REG_DEPTH_HI, 32'h0005_0000);
    add_pixel(32'h0005_FFFF);
    add_known(32'h0006_0000, 8'd255, 8'd255, 8'd255);
    // A write past the last register changes nothing.
    add_write(REG_UNUSED, 32'hFFFF_FFFF);
    add_pixel(32'h0005_4000);
    add_write(dtc_pkg::REG_COLORIZE, 32'd1);
    add_write(dtc_pkg::REG_DEPTH_LO, 32'd0);
    add_write(dtc_pkg::REG_DEPTH_HI, DEPTH_MAX);
    add_known(DEPTH_MAX, 8'd251, 8'd119, 8'd20);
    add_pixel(32'h7FFF_FFFF);
    add_pixel(32'h0000_0001);
    add_write(dtc_pkg::REG_DEPTH_LO, DEPTH_MAX);
    add_write(dtc_pkg::REG_DEPTH_HI, 32'd0);
    add_known(DEPTH_MAX, 8'd48, 8'd18, 8'd59);
    add_known(32'd0, 8'd48, 8'd18, 8'd59);
    add_write(dtc_pkg::REG_DEPTH_LO, 32'h0000_1234);
    add_write(dtc_pkg::REG_DEPTH_HI, 32'h0000_1235);
    add_known(32'h0000_1234, 8'd48, 8'd18, 8'd59);
    add_known(32'h0000_1235, 8'd251, 8'd119, 8'd20);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        stop_and_drain();
        write_reg(plan[i].idx, plan[i].value);
      end else begin
        want = plan[i].known ? plan[i].color : color_of_depth(plan[i].value);
        send_pixel(plan[i].value, $urandom_range(0, 2), want);
      end
    end

    pixels_sent = 0;
    while (pixels_sent < RANDOM_PIXELS) begin
      stop_and_drain();
      new_window();
      phase_len = $urandom_range(10, 120);
      burst = ($urandom_range(0, 3) == 0);
      repeat (phase_len) begin
        depth_pick: begin
          logic [31:0] d;
          d = pick_depth();
          send_pixel(d, burst ? 0 : pick_gap(), color_of_depth(d));
        end
      end
    end

    stop_and_drain();
    repeat (LATENCY + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
